// ----- rtl/trss_pkg.sv -----
package trss_pkg;

  localparam logic [15:0] HoldReset  = 16'd3000;
  localparam logic [2:0]  TripTotals = 3'd2;
  localparam logic [2:0]  TripCumul  = 3'd4;
  localparam logic [2:0]  TripBoth   = 3'd7;

  typedef enum logic [0:0] {
    OpUpdate  = 1'b0,
    OpProcess = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    RpIdle   = 4'b0001,
    RpBefore = 4'b0010,
    RpReset  = 4'b0100,
    RpAfter  = 4'b1000
  } reset_phase_e;

  typedef enum logic [2:0] {
    CpIdle    = 3'b001,
    CpAlive   = 3'b010,
    CpStandby = 3'b100
  } comfort_phase_e;

  typedef struct packed {
    logic        operation;
    logic        ignition_on;
    logic        trip_button;
    logic [2:0]  trip_code;
    logic [31:0] now_ms;
  } trss_req_t;

  typedef struct packed {
    logic reset_totals;
    logic reset_cumulative;
    logic keep_alive;
  } trss_rsp_t;

endpackage

// ----- rtl/trss_if.sv -----
interface trss_req_if;
  import trss_pkg::*;

  logic      valid;
  logic      ready;
  trss_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trss_rsp_if;
  import trss_pkg::*;

  logic      valid;
  logic      ready;
  trss_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/trip_reset_status_sequencer.sv -----
// Trip reset and status sequencer.
// in_req_i: request channel (valid/ready). An update request samples ignition,
//   trip button, trip code and the millisecond time; it yields no status.
//   A process request advances the reset or comfort sequence and yields at
//   most one status on out_rsp_o.
// out_rsp_o: status channel (valid/ready) with reset_totals, reset_cumulative
//   and keep_alive.
// cfg_we_i/cfg_wdata_i: writes hold_time_ms; reset value 3000.
// Status path: a status is registered in the result register or the skid.
// Throughput: one request per cycle if skid empty; all state set on accept.
// Stall: a result register plus one skid entry; with the receiver stalled,
//   requests that yield no status keep flowing, one more status-producing
//   request is taken into the skid, then ready drops until the skid drains.
// Reset: all sequence state idle, ignition and button cleared, no status
//   pending, hold time back to 3000 ms.
module trip_reset_status_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  trss_req_if.sink           in_req_i,
  trss_rsp_if.source         out_rsp_o
);
  import trss_pkg::*;

  logic [15:0]    hold_q;
  logic           ign_now_q, ign_now_d;
  logic           ign_before_q, ign_before_d;
  logic [2:0]     sel_trip_q, sel_trip_d;
  logic           held_q, held_d;
  logic [31:0]    press_time_q, press_time_d;
  logic           press_valid_q, press_valid_d;
  reset_phase_e   rp_q, rp_d;
  comfort_phase_e cp_q, cp_d;

  logic           has_rsp;
  trss_rsp_t      rsp;
  logic           accept, push, pop;
  logic           out_valid_q, skid_valid_q;
  trss_rsp_t      out_data_q, skid_data_q;
  logic [31:0]    elapsed;
  trss_req_t      req;

  assign req     = in_req_i.data;
  assign elapsed = req.now_ms - press_time_q;

  always_comb begin
    ign_now_d     = ign_now_q;
    ign_before_d  = ign_before_q;
    sel_trip_d    = sel_trip_q;
    held_d        = held_q;
    press_time_d  = press_time_q;
    press_valid_d = press_valid_q;
    rp_d          = rp_q;
    cp_d          = cp_q;
    has_rsp       = 1'b0;
    rsp           = '0;
    if (op_e'(req.operation) == OpUpdate) begin
      ign_now_d = req.ignition_on;
      if (req.ignition_on) begin
        sel_trip_d = req.trip_code;
        if (req.trip_button && !held_q) begin
          held_d        = 1'b1;
          press_time_d  = req.now_ms;
          press_valid_d = 1'b1;
        end
        if (!req.trip_button && held_q) begin
          rp_d          = RpIdle;
          held_d        = 1'b0;
          press_time_d  = '0;
          press_valid_d = 1'b0;
        end
        // fresh press gives zero elapsed, so only an existing hold can arm
        if (rp_q == RpIdle && req.trip_button && held_q && press_valid_q &&
            elapsed > {16'd0, hold_q}) begin
          rp_d = RpBefore;
        end
      end
    end else begin
      if (ign_now_q) begin
        case (rp_q)
          RpBefore: begin
            has_rsp        = 1'b1;
            rsp.keep_alive = 1'b1;
            rp_d           = RpReset;
          end
          RpReset: begin
            has_rsp              = 1'b1;
            rsp.keep_alive       = 1'b1;
            rsp.reset_totals     = sel_trip_q inside {TripTotals, TripBoth};
            rsp.reset_cumulative = sel_trip_q inside {TripCumul, TripBoth};
            rp_d                 = RpAfter;
          end
          RpAfter: begin
            has_rsp        = 1'b1;
            rsp.keep_alive = 1'b1;
            rp_d           = RpIdle;
          end
          default: rp_d = RpIdle;
        endcase
      end else begin
        case (ign_before_q ? CpAlive : cp_q)
          CpAlive: begin
            has_rsp        = 1'b1;
            rsp.keep_alive = 1'b1;
            cp_d           = CpStandby;
          end
          CpStandby: begin
            has_rsp = 1'b1;
            cp_d    = CpIdle;
          end
          default: cp_d = CpIdle;
        endcase
      end
      ign_before_d = ign_now_q;
    end
  end

  assign in_req_i.ready  = !skid_valid_q;
  assign accept          = in_req_i.valid && in_req_i.ready;
  assign push            = accept && has_rsp;
  assign pop             = out_valid_q && out_rsp_o.ready;
  assign out_rsp_o.valid = out_valid_q;
  assign out_rsp_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q        <= HoldReset;
      ign_now_q     <= 1'b0;
      ign_before_q  <= 1'b0;
      sel_trip_q    <= '0;
      held_q        <= 1'b0;
      press_time_q  <= '0;
      press_valid_q <= 1'b0;
      rp_q          <= RpIdle;
      cp_q          <= CpIdle;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      if (accept) begin
        ign_now_q     <= ign_now_d;
        ign_before_q  <= ign_before_d;
        sel_trip_q    <= sel_trip_d;
        held_q        <= held_d;
        press_time_q  <= press_time_d;
        press_valid_q <= press_valid_d;
        rp_q          <= rp_d;
        cp_q          <= cp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_data_q <= rsp;
      end else begin
        skid_data_q <= rsp;
      end
    end
  end

endmodule
